### hw/rtl/ewss_pkg.sv
// shared constants, types and lookup functions for the steering selector
// used by eight_way_steering_selector_core; no dependencies
package ewss_pkg;

    // coordinate width taken from each position port
    localparam int COORD_BITS = 12;
    // map size register width
    localparam int SIZE_BITS = 13;
    // signed delta width, wide enough for a difference plus one fold
    localparam int D_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
    // magnitude width after abs
    localparam int A_BITS = D_BITS - 1;
    // product width for the 100 and 241 ratio test
    localparam int P_BITS = A_BITS + 8;
    // config port index width
    localparam int CFG_IDX_BITS = 2;

    // config register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT = 2'd1;

    // reset map size
    localparam logic [SIZE_BITS-1:0] MAP_SIZE_RESET = 13'd128;

    // ratio test weights
    localparam logic [7:0] RATIO_LO = 8'd100;
    localparam logic [7:0] RATIO_HI = 8'd241;

    // request types
    typedef enum logic [1:0] {
        REQ_SEEK   = 2'd0,
        REQ_ESCAPE = 2'd1,
        REQ_ROTATE = 2'd2
    } t_req;

    // directions, clockwise from top-left
    localparam logic [3:0] DIR_TL   = 4'd0;
    localparam logic [3:0] DIR_T    = 4'd1;
    localparam logic [3:0] DIR_TR   = 4'd2;
    localparam logic [3:0] DIR_R    = 4'd3;
    localparam logic [3:0] DIR_BR   = 4'd4;
    localparam logic [3:0] DIR_B    = 4'd5;
    localparam logic [3:0] DIR_BL   = 4'd6;
    localparam logic [3:0] DIR_L    = 4'd7;
    localparam logic [3:0] DIR_NONE = 4'd8;

    // search offsets around the seek candidate
    function automatic logic [2:0] seek_offset(input logic [2:0] k);
        logic [2:0] off;
        case (k)
            3'd0: off = 3'd0;
            3'd1: off = 3'd1;
            3'd2: off = 3'd7;
            3'd3: off = 3'd2;
            3'd4: off = 3'd6;
            3'd5: off = 3'd3;
            3'd6: off = 3'd5;
            default: off = 3'd4;
        endcase
        return off;
    endfunction

    // quantized direction from the sign pair of the step
    function automatic logic [3:0] quant_dir(input logic signed [1:0] cy,
                                             input logic signed [1:0] cx);
        logic [3:0] d;
        case ({cy, cx})
            4'b11_11: d = DIR_TL;
            4'b11_00: d = DIR_T;
            4'b11_01: d = DIR_TR;
            4'b00_11: d = DIR_L;
            4'b00_01: d = DIR_R;
            4'b01_11: d = DIR_BL;
            4'b01_00: d = DIR_B;
            4'b01_01: d = DIR_BR;
            default:  d = DIR_NONE;
        endcase
        return d;
    endfunction

    // horizontal step of a direction
    function automatic logic signed [1:0] dir_dx(input logic [3:0] d);
        logic signed [1:0] s;
        case (d)
            DIR_TL, DIR_BL, DIR_L: s = -2'sd1;
            DIR_TR, DIR_R, DIR_BR: s = 2'sd1;
            default:               s = 2'sd0;
        endcase
        return s;
    endfunction

    // vertical step of a direction
    function automatic logic signed [1:0] dir_dy(input logic [3:0] d);
        logic signed [1:0] s;
        case (d)
            DIR_TL, DIR_T, DIR_TR: s = -2'sd1;
            DIR_BR, DIR_B, DIR_BL: s = 2'sd1;
            default:               s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/eight_way_steering_selector_core.sv
// eight-direction steering selector pipeline
// depends on ewss_pkg for widths, codes and direction tables
//
// Usage
//   Input channel: i_valid with request fields, o_stall back to the sender.
//   A transaction moves at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid with result fields, i_stall from the receiver.
//   Config channel: i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready
//   (always high); index 0 is map width, index 1 map height, other indexes
//   are ignored. Write the map size only while no request is in flight.
// Throughput and stages
//   One request per cycle sustained while the output is not stalled.
//   Stages: delta, wrap fold, abs and constant multiplies, ratio test and
//   quantize, ordered search over the free mask into the output register.
// Reset and stall
//   Synchronous active-low reset clears all stage valids and sets both map
//   sizes to 128. While the output is valid and i_stall is high the whole
//   pipeline holds and o_stall is raised; nothing is dropped or repeated.
module eight_way_steering_selector_core
    import ewss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic [COORD_BITS-1:0]   i_pos_x,
    input  logic [COORD_BITS-1:0]   i_pos_y,
    input  logic [COORD_BITS-1:0]   i_target_x,
    input  logic [COORD_BITS-1:0]   i_target_y,
    input  logic [3:0]              i_start_direction,
    input  logic [8:0]              i_free_mask,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [3:0]              o_chosen_direction,
    output logic signed [1:0]       o_step_dx,
    output logic signed [1:0]       o_step_dy,
    output logic                    o_blocked,
    // config channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [SIZE_BITS-1:0]    i_cfg_data
);

    // pipeline advance
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // config registers
    logic [SIZE_BITS-1:0] r_map_width;
    logic [SIZE_BITS-1:0] r_map_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= MAP_SIZE_RESET;
            r_map_height <= MAP_SIZE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MAP_WIDTH) begin
                r_map_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_MAP_HEIGHT) begin
                r_map_height <= i_cfg_data;
            end
        end
    end

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: request decode and raw delta
    logic                     n_rot1;
    logic [3:0]               n_start1;
    logic signed [D_BITS-1:0] n_dx1, n_dy1;
    logic                     r_rot1, r_rot2, r_rot3, r_rot4;
    logic [3:0]               r_start1, r_start2, r_start3;
    logic [8:0]               r_mask1, r_mask2, r_mask3, r_mask4, r_mask5;
    logic signed [D_BITS-1:0] r_dx1, r_dy1;

    always_comb begin
        logic signed [D_BITS-1:0] px, py, tx, ty;
        px = $signed({{(D_BITS-COORD_BITS){1'b0}}, i_pos_x});
        py = $signed({{(D_BITS-COORD_BITS){1'b0}}, i_pos_y});
        tx = $signed({{(D_BITS-COORD_BITS){1'b0}}, i_target_x});
        ty = $signed({{(D_BITS-COORD_BITS){1'b0}}, i_target_y});
        n_start1 = (i_start_direction > DIR_NONE) ? DIR_NONE : i_start_direction;
        case (i_req_type)
            REQ_SEEK: begin
                n_rot1 = 1'b0;
                n_dx1  = tx - px;
                n_dy1  = ty - py;
            end
            REQ_ESCAPE: begin
                n_rot1 = 1'b0;
                n_dx1  = px - tx;
                n_dy1  = py - ty;
            end
            default: begin
                n_rot1 = 1'b1;
                n_dx1  = tx - px;
                n_dy1  = ty - py;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot1   <= n_rot1;
            r_start1 <= n_start1;
            r_mask1  <= i_free_mask;
            r_dx1    <= n_dx1;
            r_dy1    <= n_dy1;
        end
    end

    // stage 2: wrap fold into half the map size
    function automatic logic signed [D_BITS-1:0] fold(input logic signed [D_BITS-1:0] d,
                                                      input logic [SIZE_BITS-1:0] size);
        logic signed [D_BITS-1:0] sz, half, res;
        sz   = $signed({{(D_BITS-SIZE_BITS){1'b0}}, size});
        half = $signed({{(D_BITS-SIZE_BITS+1){1'b0}}, size[SIZE_BITS-1:1]});
        if (d > half) begin
            res = d - sz;
        end else if (d < -half) begin
            res = d + sz;
        end else begin
            res = d;
        end
        return res;
    endfunction

    logic signed [D_BITS-1:0] r_dx2, r_dy2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot2   <= r_rot1;
            r_start2 <= r_start1;
            r_mask2  <= r_mask1;
            r_dx2    <= fold(r_dx1, r_map_width);
            r_dy2    <= fold(r_dy1, r_map_height);
        end
    end

    // stage 3: signs, magnitudes and constant products
    function automatic logic signed [1:0] sgn(input logic signed [D_BITS-1:0] v);
        logic signed [1:0] s;
        if (v > 0) begin
            s = 2'sd1;
        end else if (v < 0) begin
            s = -2'sd1;
        end else begin
            s = 2'sd0;
        end
        return s;
    endfunction

    function automatic logic [A_BITS-1:0] absv(input logic signed [D_BITS-1:0] v);
        logic signed [D_BITS-1:0] a;
        a = (v < 0) ? -v : v;
        return a[A_BITS-1:0];
    endfunction

    logic [A_BITS-1:0]  n_ax3, n_ay3;
    logic signed [1:0]  r_sx3, r_sy3;
    logic [P_BITS-1:0]  r_ax_lo3, r_ax_hi3, r_ay_lo3, r_ay_hi3;

    assign n_ax3 = absv(r_dx2);
    assign n_ay3 = absv(r_dy2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot3   <= r_rot2;
            r_start3 <= r_start2;
            r_mask3  <= r_mask2;
            r_sx3    <= sgn(r_dx2);
            r_sy3    <= sgn(r_dy2);
            r_ax_lo3 <= {8'd0, n_ax3} * {{A_BITS{1'b0}}, RATIO_LO};
            r_ax_hi3 <= {8'd0, n_ax3} * {{A_BITS{1'b0}}, RATIO_HI};
            r_ay_lo3 <= {8'd0, n_ay3} * {{A_BITS{1'b0}}, RATIO_LO};
            r_ay_hi3 <= {8'd0, n_ay3} * {{A_BITS{1'b0}}, RATIO_HI};
        end
    end

    // stage 4: ratio test and search base
    logic [3:0] n_base4, r_base4;

    always_comb begin
        logic signed [1:0] cx, cy;
        if (r_ax_lo3 > r_ay_hi3) begin
            cx = r_sx3;
            cy = 2'sd0;
        end else if (r_ay_lo3 > r_ax_hi3) begin
            cx = 2'sd0;
            cy = r_sy3;
        end else begin
            cx = r_sx3;
            cy = r_sy3;
        end
        n_base4 = r_rot3 ? r_start3 : quant_dir(cy, cx);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot4   <= r_rot3;
            r_base4  <= n_base4;
            r_mask4  <= r_mask3;
        end
    end

    // stage 5: ordered search over the free mask
    logic [3:0]        n_dir5;
    logic              n_found5;
    logic [3:0]        r_dir5;
    logic signed [1:0] r_dx5, r_dy5;
    logic              r_blocked5;

    always_comb begin
        logic [3:0] tries [8];
        logic [2:0] off;
        for (int k = 0; k < 8; k++) begin
            off = r_rot4 ? 3'(k) : seek_offset(3'(k));
            tries[k] = (k == 0) ? r_base4 : {1'b0, r_base4[2:0] + off};
        end
        n_found5 = 1'b0;
        n_dir5   = DIR_NONE;
        for (int k = 7; k >= 0; k--) begin
            if (r_mask4[tries[k]]) begin
                n_found5 = 1'b1;
                n_dir5   = tries[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dir5     <= n_dir5;
            r_dx5      <= dir_dx(n_dir5);
            r_dy5      <= dir_dy(n_dir5);
            r_blocked5 <= !n_found5;
            r_mask5    <= r_mask4;
        end
    end

    assign o_valid            = r_v5;
    assign o_chosen_direction = r_dir5;
    assign o_step_dx          = r_dx5;
    assign o_step_dy          = r_dy5;
    assign o_blocked          = r_blocked5;

    // a blocked result always reports none with a zero step
    a_blocked_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_blocked |->
            o_chosen_direction == DIR_NONE && o_step_dx == 0 && o_step_dy == 0)
        else $error("blocked result without none direction");

    // a chosen direction was free in the mask of that request
    a_chosen_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_blocked |-> r_mask5[o_chosen_direction])
        else $error("chosen direction not free");

    // a real direction always moves
    a_dir_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chosen_direction != DIR_NONE |-> o_step_dx != 0 || o_step_dy != 0)
        else $error("direction with zero step");

    // a stalled result holds through the pipeline freeze
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_chosen_direction) && $stable(o_blocked))
        else $error("stalled result changed");

endmodule
